FILE: hdl/ppa_pkg.sv
// Shared types and constants for the partition placement allocator.
// Holds result status codes, placement policy codes and the fixed field widths.
// No dependencies; every other file of the block but ppa_size_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

	// Fixed widths of the transaction fields.
	localparam int REQ_SIZE_W = 16;
	localparam int STATUS_W   = 2;
	localparam int PN_W       = 5;
	localparam int RNUM_W     = 16;
	localparam int WASTE_W    = 16;
	localparam int SUM_W      = 20;
	localparam int POLICY_W   = 3;

	// Configuration port widths.
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_POLICY = 2'd0;

	// Request kinds.
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_ALLOC  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	// Placement policy codes; unused codes behave as first fit.
	localparam logic [POLICY_W-1:0] POL_FIRST = 3'd0;
	localparam logic [POLICY_W-1:0] POL_NEXT  = 3'd1;
	localparam logic [POLICY_W-1:0] POL_BEST  = 3'd2;
	localparam logic [POLICY_W-1:0] POL_WORST = 3'd3;
	localparam logic [POLICY_W-1:0] POL_SPLIT = 3'd4;

	// Verdict of the shared fit unit for one scanned partition.
	typedef struct packed {
		logic fit;
		logic take;
	} fit_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/ppa_size_ram.sv
// Partition size memory: one write port and one read port with registered data.
// Free partitions keep their full size here, which is also the space they have left.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module ppa_size_ram #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/ppa_fit_unit.sv
// Shared fit unit: one subtract and one compare, reused for every scanned partition.
// Decides whether a partition fits and whether it beats the current choice.
// Depends on ppa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppa_fit_unit #(
	parameter int SIZE_W = 16
) (
	input  wire logic [ppa_pkg::POLICY_W-1:0] policy,
	input  wire logic [SIZE_W-1:0]            part_size,
	input  wire logic                         part_busy,
	input  wire logic [SIZE_W-1:0]            req_size,
	input  wire logic                         found,
	input  wire logic [SIZE_W-1:0]            best_waste,
	output ppa_pkg::fit_ctl_t                 ctl,
	output logic      [SIZE_W-1:0]            waste
);

	import ppa_pkg::*;

	logic [SIZE_W:0] diff;
	logic            better;
	logic            fit_ok;

	// The borrow of the subtraction tells whether the request fits.
	assign diff  = {1'b0, part_size} - {1'b0, req_size};
	assign waste = diff[SIZE_W-1:0];

	// Best fit keeps the smallest waste and worst fit the largest; ties go to the later entry.
	always_comb begin
		case (policy)
			POL_BEST: begin
				better = (waste <= best_waste);
			end
			POL_WORST, POL_SPLIT: begin
				better = (waste >= best_waste);
			end
			default: begin
				better = 1'b0;
			end
		endcase
	end

	assign fit_ok = !part_busy && !diff[SIZE_W];
	assign ctl    = '{fit: fit_ok, take: fit_ok && (!found || better)};

endmodule

`default_nettype wire

FILE: hdl/partition_placement_allocator_top.sv
// Top level of the partition placement allocator: sequencer, state and APB register.
// Depends on ppa_pkg, ppa_size_ram and ppa_fit_unit.
`timescale 1ns / 1ps
`default_nettype none

// The allocator keeps a table of up to MAX_PARTITIONS fixed partitions. An append
// transaction adds a free partition and passes from acceptance through the commit
// and report states to a valid result. An allocate transaction scans the partitions
// one per cycle through the size memory's single read port and one shared fit
// comparator, from the next-fit pointer or from zero up to the current count, then
// commits and reports. One transaction is processed at a time; in_ready is low while
// it is in progress. A finished result is held in the output register, and a new
// transaction may be accepted while it waits to be taken. The placement policy is set
// through the APB register at address 0 and should only be changed while idle.

module partition_placement_allocator_top #(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           req_type,
	input  wire logic [ppa_pkg::REQ_SIZE_W-1:0] request_size,
	// Output channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [ppa_pkg::STATUS_W-1:0]   status,
	output logic      [ppa_pkg::PN_W-1:0]       partition_number,
	output logic      [ppa_pkg::RNUM_W-1:0]     request_number,
	output logic      [ppa_pkg::WASTE_W-1:0]    waste,
	output logic      [ppa_pkg::SUM_W-1:0]      total_waste,
	// Configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ppa_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ppa_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ppa_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);

	import ppa_pkg::*;

	localparam int SW = (SIZE_BITS < REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;
	localparam int IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CW = $clog2(MAX_PARTITIONS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT,
		S_REPORT
	} state_t;

	state_t                 state_q;
	logic [POLICY_W-1:0]    policy_q;
	logic                   req_type_q;
	logic [SW-1:0]          req_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          next_q;
	logic [RNUM_W-1:0]      reqnum_q;
	logic [SUM_W-1:0]       sum_q;
	logic [MAX_PARTITIONS-1:0] busy_q;
	logic [CW-1:0]          issue_q;
	logic [IW-1:0]          cmp_idx_s1;
	logic                   rd_vld_s1;
	logic                   found_q;
	logic [IW-1:0]          pick_q;
	logic [SW-1:0]          bestw_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [PN_W-1:0]        res_pn_q;
	logic [RNUM_W-1:0]      res_rnum_q;
	logic [WASTE_W-1:0]     res_waste_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [PN_W-1:0]        pn_q;
	logic [RNUM_W-1:0]      rnum_q;
	logic [WASTE_W-1:0]     waste_q;
	logic [SUM_W-1:0]       total_q;

	logic                   in_acc;
	logic                   out_acc;
	logic                   cfg_wr;
	logic                   issue_lt;
	logic                   full;
	logic                   split;
	logic [SW-1:0]          left_eff;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_sat;
	logic                   ram_we;
	logic [SW-1:0]          ram_wdata;
	logic [SW-1:0]          ram_rdata;
	fit_ctl_t               fit_ctl;
	logic [SW-1:0]          fit_waste;

	// Handshakes.
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid_q && out_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// Scan and commit helpers.
	assign issue_lt = (state_q == S_SCAN) && (issue_q < count_q);
	assign full     = (count_q >= CW'(MAX_PARTITIONS));
	assign split    = (policy_q == POL_SPLIT) && (bestw_q != '0) && !full;
	assign left_eff = split ? '0 : bestw_q;
	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(left_eff);
	assign sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	// The memory is written by an append and by the leftover of a split placement.
	assign ram_we = (state_q == S_COMMIT) &&
		((req_type_q == REQ_APPEND) ? !full : (found_q && split));
	assign ram_wdata = (req_type_q == REQ_APPEND) ? req_q : bestw_q;

	ppa_size_ram #(
		.DEPTH (MAX_PARTITIONS),
		.DATA_W(SW),
		.ADDR_W(IW)
	) u_size_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IW-1:0]),
		.wdata(ram_wdata),
		.re   (issue_lt),
		.raddr(issue_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	ppa_fit_unit #(
		.SIZE_W(SW)
	) u_fit_unit (
		.policy    (policy_q),
		.part_size (ram_rdata),
		.part_busy (busy_q[cmp_idx_s1]),
		.req_size  (req_q),
		.found     (found_q),
		.best_waste(bestw_q),
		.ctl       (fit_ctl),
		.waste     (fit_waste)
	);

	// Sequencer, allocator state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FIRST;
			req_type_q   <= REQ_APPEND;
			req_q        <= '0;
			count_q      <= '0;
			next_q       <= '0;
			reqnum_q     <= '0;
			sum_q        <= '0;
			busy_q       <= '0;
			issue_q      <= '0;
			cmp_idx_s1   <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			bestw_q      <= '0;
			res_status_q <= ST_APPENDED;
			res_pn_q     <= '0;
			res_rnum_q   <= '0;
			res_waste_q  <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_APPENDED;
			pn_q         <= '0;
			rnum_q       <= '0;
			waste_q      <= '0;
			total_q      <= '0;
		end else begin
			if (cfg_wr && (paddr == ADDR_POLICY)) begin
				policy_q <= pwdata[POLICY_W-1:0];
			end
			// In the report state the hand-over below sets the valid flag itself.
			if (out_acc && (state_q != S_REPORT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_type_q <= req_type;
						req_q      <= request_size[SW-1:0];
						found_q    <= 1'b0;
						bestw_q    <= '0;
						pick_q     <= '0;
						rd_vld_s1  <= 1'b0;
						issue_q    <= (policy_q == POL_NEXT) ? next_q : '0;
						if (req_type == REQ_ALLOC) begin
							reqnum_q <= reqnum_q + RNUM_W'(1);
							state_q  <= S_SCAN;
						end else begin
							state_q  <= S_COMMIT;
						end
					end
				end

				S_SCAN: begin
					// Issue one read a cycle; judge the data read in the previous cycle.
					rd_vld_s1  <= issue_lt;
					cmp_idx_s1 <= issue_q[IW-1:0];
					if (issue_lt) begin
						issue_q <= issue_q + CW'(1);
					end
					if (rd_vld_s1 && fit_ctl.take) begin
						found_q <= 1'b1;
						pick_q  <= cmp_idx_s1;
						bestw_q <= fit_waste;
					end
					if (!issue_lt && !rd_vld_s1) begin
						state_q <= S_COMMIT;
					end
				end

				S_COMMIT: begin
					res_rnum_q  <= (req_type_q == REQ_ALLOC) ? reqnum_q : '0;
					res_waste_q <= '0;
					res_pn_q    <= '0;
					if (req_type_q == REQ_APPEND) begin
						if (full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_APPENDED;
							res_pn_q     <= PN_W'(count_q + CW'(1));
							count_q      <= count_q + CW'(1);
							busy_q[count_q[IW-1:0]] <= 1'b0;
							next_q       <= '0;
						end
					end else if (!found_q) begin
						res_status_q <= ST_NOFIT;
					end else begin
						res_status_q   <= ST_PLACED;
						res_pn_q       <= PN_W'((IW + 1)'(pick_q) + (IW + 1)'(1));
						res_waste_q    <= WASTE_W'(left_eff);
						busy_q[pick_q] <= 1'b1;
						sum_q          <= sum_sat;
						if (policy_q == POL_NEXT) begin
							next_q <= CW'(pick_q) + CW'(1);
						end
						if (split) begin
							count_q <= count_q + CW'(1);
						end
					end
					state_q <= S_REPORT;
				end

				S_REPORT: begin
					// Hand the result over once the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						pn_q        <= res_pn_q;
						rnum_q      <= res_rnum_q;
						waste_q     <= res_waste_q;
						total_q     <= sum_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output channel and register read-back.
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign partition_number = pn_q;
	assign request_number   = rnum_q;
	assign waste            = waste_q;
	assign total_waste      = total_q;
	assign pready           = 1'b1;
	assign prdata           = (paddr == ADDR_POLICY) ? APB_DATA_W'(policy_q) : '0;

endmodule

`default_nettype wire

FILE: hdl/ppa_checker.sv
// Port-level checker for the partition placement allocator, with its bind statement.
// Depends on ppa_pkg and on partition_placement_allocator_top being elaborated.
`timescale 1ns / 1ps
`default_nettype none

module ppa_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [ppa_pkg::STATUS_W-1:0] status,
	input wire logic [ppa_pkg::PN_W-1:0]     partition_number,
	input wire logic [ppa_pkg::RNUM_W-1:0]   request_number,
	input wire logic [ppa_pkg::WASTE_W-1:0]  waste
);

	import ppa_pkg::*;

	// An accepted transaction keeps the input blocked while it passes through the commit and report states.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready)
		else $error("input accepted again too early");

	// A new result only appears at the end of processing, while the input is blocked.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without processing");

	// A stalled result stays valid and holds its status, partition number and waste.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(status) &&
		$stable(partition_number) && $stable(waste))
		else $error("stalled result changed");

	// Results without a placement carry no partition and no waste.
	a_no_place_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NOFIT || status == ST_FULL)) |->
		(partition_number == '0) && (waste == '0))
		else $error("unplaced result carries a partition or waste");

	// Appends carry no request number.
	a_append_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_APPENDED || status == ST_FULL)) |->
		(request_number == '0))
		else $error("append result carries a request number");

endmodule

bind partition_placement_allocator_top ppa_checker u_ppa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.partition_number(partition_number),
	.request_number  (request_number),
	.waste           (waste)
);

`default_nettype wire

FILE: tb/partition_placement_allocator_top_test.sv
// Self-checking testbench for partition_placement_allocator_top: directed and random traffic.
// Keeps its own copy of the partition table to predict every result; needs ppa_pkg and the RTL.
`timescale 1ns / 1ps

module partition_placement_allocator_top_test;
	import ppa_pkg::*;

	localparam int NUM_PARTS       = 16;
	localparam int SUM_LIMIT       = (1 << SUM_W) - 1;
	localparam int RANDOM_ROUNDS   = 16;
	localparam int ROUND_ITEMS     = 100;
	localparam int DRAIN_CYCLES    = 40;
	localparam int TIMEOUT_NS      = 100_000_000;

	// Policy codes with no meaning of their own; the block treats them as first fit.
	localparam logic [POLICY_W-1:0] POL_SPARE_LO = 3'd5;
	localparam logic [POLICY_W-1:0] POL_SPARE_HI = 3'd7;
	localparam logic [POLICY_W-1:0] OPENING_POLICIES [4] =
		'{POL_SPARE_HI, POL_SPLIT, POL_NEXT, POL_SPARE_LO};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PN_W-1:0]     part_no;
		logic [RNUM_W-1:0]   req_no;
		logic [WASTE_W-1:0]  waste;
		logic [SUM_W-1:0]    total;
	} alloc_result_t;

	// Shadow partition table, predicted results and the mismatch count.
	class partition_ledger;
		bit [REQ_SIZE_W-1:0] part_size [NUM_PARTS];
		bit [REQ_SIZE_W-1:0] part_space [NUM_PARTS];
		bit                  part_taken [NUM_PARTS];
		int unsigned         part_count;
		int unsigned         next_fit_from;
		bit [RNUM_W-1:0]     req_seq;
		int unsigned         waste_acc;
		bit [POLICY_W-1:0]   policy;
		alloc_result_t       expected_q [$];
		int unsigned         errors;

		task report(input string msg);
			errors++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		function void add_partition(input int unsigned size);
			part_size[part_count]  = REQ_SIZE_W'(size);
			part_space[part_count] = REQ_SIZE_W'(size);
			part_taken[part_count] = 1'b0;
			part_count++;
		endfunction

		// Work out the result of one accepted transaction and queue it.
		function void note_request(input logic kind, input logic [REQ_SIZE_W-1:0] size);
			alloc_result_t r;
			bit            found;
			int unsigned   j, pick, margin, best_margin, left;
			r = '0;
			found = 1'b0;
			pick = 0;
			best_margin = 0;
			if (kind == REQ_APPEND) begin
				if (part_count >= NUM_PARTS) begin
					r.status = ST_FULL;
				end else begin
					add_partition(size);
					next_fit_from = 0;
					r.status = ST_APPENDED;
					r.part_no = PN_W'(part_count);
				end
				r.total = SUM_W'(waste_acc);
				expected_q.push_back(r);
				return;
			end

			req_seq++;
			r.req_no = req_seq;
			if (policy == POL_BEST || policy == POL_WORST || policy == POL_SPLIT) begin
				// Full scan; ties go to the highest index.
				for (j = 0; j < part_count; j++) begin
					if (!part_taken[j] && part_size[j] >= size) begin
						margin = (part_space[j] >= size) ? part_space[j] - size : 0;
						if (!found || (policy == POL_BEST ? margin <= best_margin
								: margin >= best_margin)) begin
							best_margin = margin;
							pick = j;
							found = 1'b1;
						end
					end
				end
			end else begin
				// First fit from zero, or next fit from the pointer with no wrap.
				j = (policy == POL_NEXT) ? next_fit_from : 0;
				while (!found && j < part_count) begin
					if (!part_taken[j] && part_size[j] >= size) begin
						pick = j;
						found = 1'b1;
					end
					j++;
				end
			end

			if (!found) begin
				r.status = ST_NOFIT;
				r.total = SUM_W'(waste_acc);
				expected_q.push_back(r);
				return;
			end

			part_taken[pick] = 1'b1;
			left = (part_space[pick] >= size) ? part_space[pick] - size : 0;
			part_space[pick] = REQ_SIZE_W'(left);
			if (policy == POL_NEXT)
				next_fit_from = pick + 1;
			// The splitting policy turns the leftover into a new partition when there is room.
			if (policy == POL_SPLIT && left != 0 && part_count < NUM_PARTS) begin
				add_partition(left);
				part_space[pick] = 0;
				left = 0;
			end
			waste_acc = (waste_acc + left > SUM_LIMIT) ? SUM_LIMIT : waste_acc + left;
			r.status = ST_PLACED;
			r.part_no = PN_W'(pick + 1);
			r.waste = WASTE_W'(left);
			r.total = SUM_W'(waste_acc);
			expected_q.push_back(r);
		endfunction

		// Compare one result transaction with the oldest prediction.
		task check_result(input alloc_result_t got);
			alloc_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with none expected: status %0d partition %0d",
					got.status, got.part_no));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.part_no !== want.part_no)
				report($sformatf("partition_number %0d, expected %0d",
					got.part_no, want.part_no));
			if (got.req_no !== want.req_no)
				report($sformatf("request_number %0d, expected %0d", got.req_no, want.req_no));
			if (got.waste !== want.waste)
				report($sformatf("waste %0d, expected %0d", got.waste, want.waste));
			if (got.total !== want.total)
				report($sformatf("total_waste %0d, expected %0d", got.total, want.total));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic [REQ_SIZE_W-1:0] request_size;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [PN_W-1:0]       partition_number;
	logic [RNUM_W-1:0]     request_number;
	logic [WASTE_W-1:0]    waste;
	logic [SUM_W-1:0]      total_waste;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	partition_ledger ledger = new();

	partition_placement_allocator_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.request_size     (request_size),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.partition_number (partition_number),
		.request_number   (request_number),
		.waste            (waste),
		.total_waste      (total_waste),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	initial begin
		#TIMEOUT_NS;
		$display("partition_placement_allocator_top regression: fail");
		$finish;
	end

	// Result side: take transactions with random back-pressure and check them.
	initial begin
		alloc_result_t got;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got = {status, partition_number, request_number, waste, total_waste};
				ledger.check_result(got);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
	endtask

	// Offer one transaction, with an optional random gap first, and wait for acceptance.
	task automatic send_item(input logic kind, input logic [REQ_SIZE_W-1:0] size);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		request_size <= size;
		do @(posedge clk); while (in_ready !== 1'b1);
		ledger.note_request(kind, size);
	endtask

	// Hold the sender back until every predicted result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.expected_q.size() != 0);
	endtask

	// Write the policy register while idle, then read it back.
	task automatic set_policy(input logic [POLICY_W-1:0] code);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_POLICY;
		pwdata <= APB_DATA_W'(code);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		ledger.policy = code;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== APB_DATA_W'(code))
			ledger.report($sformatf("policy read back %0d, expected %0d", prdata, code));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sizes lean towards small values so that requests find room now and then.
	function automatic logic [REQ_SIZE_W-1:0] pick_size();
		case ($urandom_range(3))
			0: return REQ_SIZE_W'($urandom_range(15));
			1: return REQ_SIZE_W'($urandom_range(1023));
			default: return REQ_SIZE_W'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned round, k;
		logic        kind;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_APPEND;
		request_size <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_POLICY;
		pwdata <= '0;
		set_idling(35, 59);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_policy(POL_FIRST);

		// First fit, with the smallest and largest sizes.
		send_item(REQ_APPEND, 16'd100);
		send_item(REQ_APPEND, 16'hFFFF);
		send_item(REQ_APPEND, 16'd0);
		send_item(REQ_APPEND, 16'd300);
		send_item(REQ_ALLOC, 16'd150);
		send_item(REQ_ALLOC, 16'd0);

		// Next fit: the last request finds nothing past the pointer although an
		// earlier partition is free.
		set_policy(POL_NEXT);
		send_item(REQ_APPEND, 16'd200);
		send_item(REQ_ALLOC, 16'd50);
		send_item(REQ_ALLOC, 16'd0);
		send_item(REQ_ALLOC, 16'd0);

		// Best fit with a tie between two equal partitions, then a request too big.
		set_policy(POL_BEST);
		send_item(REQ_APPEND, 16'd500);
		send_item(REQ_APPEND, 16'd500);
		send_item(REQ_APPEND, 16'd400);
		send_item(REQ_ALLOC, 16'd450);
		send_item(REQ_ALLOC, 16'hFFFF);

		// Worst fit with a tie.
		set_policy(POL_WORST);
		send_item(REQ_APPEND, 16'd1000);
		send_item(REQ_APPEND, 16'd1000);
		send_item(REQ_ALLOC, 16'd10);

		// Splitting worst fit: a split with room, then a full table on append,
		// then a split that finds no room and leaves the remainder as waste.
		set_policy(POL_SPLIT);
		send_item(REQ_ALLOC, 16'd100);
		send_item(REQ_APPEND, 16'd1);
		send_item(REQ_APPEND, 16'd2);
		send_item(REQ_APPEND, 16'd3);
		send_item(REQ_APPEND, 16'd4);
		send_item(REQ_APPEND, 16'd5);
		send_item(REQ_APPEND, 16'd7);
		send_item(REQ_ALLOC, 16'd1);

		// Random rounds, each under its own policy setting.
		for (round = 0; round < RANDOM_ROUNDS; round++) begin
			if (round == 5)
				set_idling(59, 35);
			if (round == 11)
				set_idling(0, 0);
			set_policy(round < 4 ? OPENING_POLICIES[round] : POLICY_W'($urandom_range(7)));
			for (k = 0; k < ROUND_ITEMS; k++) begin
				if ($urandom_range(39) == 0)
					wait_drained();
				kind = ($urandom_range(3) == 0) ? REQ_APPEND : REQ_ALLOC;
				send_item(kind, pick_size());
			end
		end

		// Let the last results out and watch for stray ones.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.expected_q.size() == 0) begin
			$display("partition_placement_allocator_top regression: pass");
		end else begin
			$display("partition_placement_allocator_top regression: fail");
		end
		$finish;
	end

endmodule
